// File: hdl/spfl_pkg.sv
// ----------------------------------------------------------------------------
// Sectioned page free list package
// Shared sizes, status codes, command and response types.
// ----------------------------------------------------------------------------
package spfl_pkg;

   localparam int SECTIONS          = 8;
   localparam int SLOTS_PER_SECTION = 1024;
   localparam int QUEUE_DEPTH       = 2;

   localparam int SEC_W   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int SLOT_W  = $clog2(SLOTS_PER_SECTION);
   localparam int CNT_W   = $clog2(SLOTS_PER_SECTION + 1);
   localparam int CFG_W   = 4;
   localparam int DEPTH   = SECTIONS * SLOTS_PER_SECTION;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK,
      ST_NO_PAGE,
      ST_BAD_SECTION,
      ST_FULL
   } status_type;

   typedef struct packed {
      logic              rd;
      logic              wr;
      logic [ADDR_W-1:0] addr;
      status_type        status;
      logic [SEC_W-1:0]  section;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  count;
   } cmd_type;

   typedef struct packed {
      status_type        status;
      logic [SEC_W-1:0]  section;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  count;
   } rsp_type;

   function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] p);
      return (p == SLOT_W'(SLOTS_PER_SECTION - 1)) ? '0 : p + SLOT_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [SEC_W-1:0] s,
                                                   input logic [SLOT_W-1:0] p);
      return ADDR_W'(s) * ADDR_W'(SLOTS_PER_SECTION) + ADDR_W'(p);
   endfunction

endpackage

// File: hdl/sectioned_page_free_list_top.sv
// ----------------------------------------------------------------------------
// Sectioned page free list
// Per-section FIFO free lists of page slots with allocate and free requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_func (0 allocate, 1 free), req_free_section
//   and req_free_slot with start; a request is taken on a rising edge with
//   start high and busy low.
//   Response channel: rsp_valid strobes for one cycle with rsp_status,
//   rsp_got_section, rsp_got_slot and rsp_section_free_count. The receiver
//   cannot stall; every response must be taken in its strobe cycle.
//   Config: csr_wr_en with csr_wr_data writes sections_in_use; write it only
//   while no request is outstanding.
// Timing:
//   An accepted request is held in the command queue, then the back end
//   registers the slot store read and the response strobe.
//   Throughput is one request per cycle while busy is low; the front end
//   settles pointers and counts at accept, and the single slot store port
//   serves one command per cycle.
// Reset:
//   Synchronous, active high. Clears all lists to empty and sets
//   sections_in_use to 1. The slot store itself is not cleared.
// ----------------------------------------------------------------------------
module sectioned_page_free_list_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_func,
   input  logic [2:0]                  req_free_section,
   input  logic [9:0]                  req_free_slot,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [2:0]                  rsp_got_section,
   output logic [9:0]                  rsp_got_slot,
   output logic [10:0]                 rsp_section_free_count,
   input  logic                        csr_wr_en,
   input  logic [3:0]                  csr_wr_data
);

   logic              accept;
   logic              q_full;
   logic              q_empty;
   spfl_pkg::cmd_type front_cmd;
   spfl_pkg::cmd_type q_cmd;
   spfl_pkg::rsp_type rsp;

   assign busy   = q_full;
   assign accept = start && !busy;

   spfl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .accept       (accept),
      .func         (req_func),
      .free_section (req_free_section),
      .free_slot    (req_free_slot),
      .cmd          (front_cmd)
   );

   spfl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .pop      (!q_empty),
      .full     (q_full),
      .empty    (q_empty),
      .head_cmd (q_cmd)
   );

   spfl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (q_cmd),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_status             = rsp.status;
   assign rsp_got_section        = rsp.section;
   assign rsp_got_slot           = rsp.slot;
   assign rsp_section_free_count = rsp.count;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("response not delivered two cycles after accept");
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("command queue filled up");
`endif

endmodule

// File: hdl/spfl_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read per cycle at the same address, registered read data.
// ----------------------------------------------------------------------------
module spfl_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/spfl_front.sv
// ----------------------------------------------------------------------------
// Sectioned page free list front end
// Classifies requests, keeps list pointers and counts, issues commands.
// ----------------------------------------------------------------------------
module spfl_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [spfl_pkg::CFG_W-1:0] csr_wr_data,
   input  logic                       accept,
   input  logic                       func,
   input  logic [spfl_pkg::SEC_W-1:0] free_section,
   input  logic [spfl_pkg::SLOT_W-1:0] free_slot,
   output spfl_pkg::cmd_type          cmd
);

   logic [spfl_pkg::CFG_W-1:0]  sections_in_use_ff;
   logic [spfl_pkg::SLOT_W-1:0] head_ff  [spfl_pkg::SECTIONS];
   logic [spfl_pkg::SLOT_W-1:0] head_in  [spfl_pkg::SECTIONS];
   logic [spfl_pkg::SLOT_W-1:0] tail_ff  [spfl_pkg::SECTIONS];
   logic [spfl_pkg::SLOT_W-1:0] tail_in  [spfl_pkg::SECTIONS];
   logic [spfl_pkg::CNT_W-1:0]  count_ff [spfl_pkg::SECTIONS];
   logic [spfl_pkg::CNT_W-1:0]  count_in [spfl_pkg::SECTIONS];

   logic [spfl_pkg::CFG_W-1:0]  n_eff;
   logic                        found;
   logic [spfl_pkg::SEC_W-1:0]  pick;
   logic [spfl_pkg::SEC_W-1:0]  idx;
   logic [spfl_pkg::CNT_W-1:0]  cnt_sel;
   logic [spfl_pkg::SLOT_W-1:0] head_sel;
   logic [spfl_pkg::SLOT_W-1:0] tail_sel;
   logic                        in_range;
   logic                        full;

   always_comb begin
      n_eff = (sections_in_use_ff > spfl_pkg::CFG_W'(spfl_pkg::SECTIONS)) ?
              spfl_pkg::CFG_W'(spfl_pkg::SECTIONS) : sections_in_use_ff;
      found = 1'b0;
      pick  = '0;
      for (int i = spfl_pkg::SECTIONS - 1; i >= 0; i--) begin
         if ((spfl_pkg::CFG_W'(i) < n_eff) && (count_ff[i] != '0)) begin
            found = 1'b1;
            pick  = spfl_pkg::SEC_W'(i);
         end
      end
      idx      = (func == spfl_pkg::FUNC_FREE) ? free_section : pick;
      cnt_sel  = count_ff[idx];
      head_sel = head_ff[idx];
      tail_sel = tail_ff[idx];
      in_range = spfl_pkg::CFG_W'(free_section) < n_eff;
      full     = cnt_sel >= spfl_pkg::CNT_W'(spfl_pkg::SLOTS_PER_SECTION);
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      cmd.rd      = 1'b0;
      cmd.wr      = 1'b0;
      cmd.addr    = '0;
      cmd.status  = spfl_pkg::ST_OK;
      cmd.section = '0;
      cmd.slot    = '0;
      cmd.count   = '0;
      if (func == spfl_pkg::FUNC_ALLOC) begin
         if (found) begin
            cmd.rd      = 1'b1;
            cmd.addr    = spfl_pkg::slot_addr(idx, head_sel);
            cmd.section = idx;
            cmd.count   = cnt_sel - spfl_pkg::CNT_W'(1);
            if (accept) begin
               head_in[idx]  = spfl_pkg::ring_next(head_sel);
               count_in[idx] = cnt_sel - spfl_pkg::CNT_W'(1);
            end
         end else begin
            cmd.status = spfl_pkg::ST_NO_PAGE;
         end
      end else begin
         cmd.section = free_section;
         cmd.slot    = free_slot;
         if (!in_range) begin
            cmd.status = spfl_pkg::ST_BAD_SECTION;
         end else if (full) begin
            cmd.status = spfl_pkg::ST_FULL;
            cmd.count  = cnt_sel;
         end else begin
            cmd.wr    = 1'b1;
            cmd.addr  = spfl_pkg::slot_addr(idx, tail_sel);
            cmd.count = cnt_sel + spfl_pkg::CNT_W'(1);
            if (accept) begin
               tail_in[idx]  = spfl_pkg::ring_next(tail_sel);
               count_in[idx] = cnt_sel + spfl_pkg::CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sections_in_use_ff <= spfl_pkg::CFG_W'(1);
         for (int i = 0; i < spfl_pkg::SECTIONS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            sections_in_use_ff <= csr_wr_data;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[idx] <= spfl_pkg::CNT_W'(spfl_pkg::SLOTS_PER_SECTION))
      else $error("free count above section capacity");
`endif

endmodule

// File: hdl/spfl_queue.sv
// ----------------------------------------------------------------------------
// Sectioned page free list command queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module spfl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  spfl_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output spfl_pkg::cmd_type head_cmd
);

   spfl_pkg::cmd_type            entry_ff [spfl_pkg::QUEUE_DEPTH];
   logic [spfl_pkg::QPTR_W-1:0]  wr_ptr_ff;
   logic [spfl_pkg::QPTR_W-1:0]  wr_ptr_in;
   logic [spfl_pkg::QPTR_W-1:0]  rd_ptr_ff;
   logic [spfl_pkg::QPTR_W-1:0]  rd_ptr_in;
   logic [spfl_pkg::QCNT_W-1:0]  cnt_ff;
   logic [spfl_pkg::QCNT_W-1:0]  cnt_in;
   logic                         do_push;
   logic                         do_pop;

   assign full     = cnt_ff == spfl_pkg::QCNT_W'(spfl_pkg::QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == spfl_pkg::QPTR_W'(spfl_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + spfl_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == spfl_pkg::QPTR_W'(spfl_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + spfl_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + spfl_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - spfl_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: hdl/spfl_back.sv
// ----------------------------------------------------------------------------
// Sectioned page free list back end
// Executes commands against the slot store and forms responses.
// ----------------------------------------------------------------------------
module spfl_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  spfl_pkg::cmd_type cmd,
   output logic              rsp_valid,
   output spfl_pkg::rsp_type rsp
);

   logic                        vld_ff;
   spfl_pkg::cmd_type           cmd_ff;
   logic [spfl_pkg::SLOT_W-1:0] rd_data;

   spfl_ram #(
      .WIDTH (spfl_pkg::SLOT_W),
      .DEPTH (spfl_pkg::DEPTH)
   ) u_slot_store (
      .clock   (clock),
      .wr_en   (cmd_valid && cmd.wr),
      .addr    (cmd.addr),
      .wr_data (cmd.slot),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= cmd_valid;
      end
      cmd_ff <= cmd;
   end

   assign rsp_valid   = vld_ff;
   assign rsp.status  = cmd_ff.status;
   assign rsp.section = cmd_ff.section;
   assign rsp.slot    = cmd_ff.rd ? rd_data : cmd_ff.slot;
   assign rsp.count   = cmd_ff.count;

`ifndef NO_ASSERTIONS
   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> !(cmd.rd && cmd.wr))
      else $error("command both reads and writes the slot store");
   a_rsp_follows_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd_valid))
      else $error("response without a command");
`endif

endmodule

// File: test/sectioned_page_free_list_checker.sv
// ----------------------------------------------------------------------------
// Sectioned page free list checker
// Watches the request, response and register ports of the free list, keeps
// its own copy of every section's ring, head, tail and count, predicts the
// response of each accepted request and compares it field by field with the
// response that comes out, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sectioned_page_free_list_checker
   import spfl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_func,
   input  logic [2:0]  req_free_section,
   input  logic [9:0]  req_free_slot,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [2:0]  rsp_got_section,
   input  logic [9:0]  rsp_got_slot,
   input  logic [10:0] rsp_section_free_count,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   output int unsigned fail_count,
   output int unsigned outstanding
);

   logic [SLOT_W-1:0] page_ring [SECTIONS][SLOTS_PER_SECTION];
   logic [SLOT_W-1:0] page_head [SECTIONS];
   logic [SLOT_W-1:0] page_tail [SECTIONS];
   logic [CNT_W-1:0]  page_count [SECTIONS];
   logic [CFG_W-1:0]  sections_cfg;
   rsp_type           expected_pages [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic logic [SLOT_W-1:0] advance_ring(input logic [SLOT_W-1:0] p);
      return (int'(p) == SLOTS_PER_SECTION - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic rsp_type serve_request(input logic func,
                                             input logic [SEC_W-1:0] sec,
                                             input logic [SLOT_W-1:0] slot);
      rsp_type           r;
      int                n;
      bit                found;
      logic [SLOT_W-1:0] p;
      n = (int'(sections_cfg) > SECTIONS) ? SECTIONS : int'(sections_cfg);
      r.status  = ST_NO_PAGE;
      r.section = '0;
      r.slot    = '0;
      r.count   = '0;
      found     = 1'b0;
      if (func == FUNC_ALLOC) begin
         for (int i = 0; i < n; i++) begin
            if (!found && page_count[i] != '0) begin
               found         = 1'b1;
               p             = page_head[i];
               r.status      = ST_OK;
               r.section     = SEC_W'(i);
               r.slot        = page_ring[i][p];
               page_head[i]  = advance_ring(p);
               page_count[i] = page_count[i] - 1'b1;
               r.count       = page_count[i];
            end
         end
      end else if (int'(sec) >= n) begin
         r.status  = ST_BAD_SECTION;
         r.section = sec;
         r.slot    = slot;
      end else if (int'(page_count[sec]) >= SLOTS_PER_SECTION) begin
         r.status  = ST_FULL;
         r.section = sec;
         r.slot    = slot;
         r.count   = page_count[sec];
      end else begin
         p                   = page_tail[sec];
         page_ring[sec][p]   = slot;
         page_tail[sec]      = advance_ring(p);
         page_count[sec]     = page_count[sec] + 1'b1;
         r.status            = ST_OK;
         r.section           = sec;
         r.slot              = slot;
         r.count             = page_count[sec];
      end
      return r;
   endfunction

   task automatic report_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s: expected %0d, got %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type oldest;
      if (reset) begin
         for (int i = 0; i < SECTIONS; i++) begin
            page_head[i]  = '0;
            page_tail[i]  = '0;
            page_count[i] = '0;
         end
         sections_cfg = CFG_W'(1);
         expected_pages.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_pages.size() == 0) begin
               $display("%0t unexpected response: expected none, got status %0d section %0d slot %0d count %0d",
                        $time, rsp_status, rsp_got_section, rsp_got_slot,
                        rsp_section_free_count);
               fail_count++;
            end else begin
               oldest = expected_pages.pop_front();
               report_field("status", oldest.status, rsp_status);
               report_field("got_section", oldest.section, rsp_got_section);
               report_field("got_slot", oldest.slot, rsp_got_slot);
               report_field("section_free_count", oldest.count, rsp_section_free_count);
            end
         end
         if (csr_wr_en)
            sections_cfg = csr_wr_data;
         if (start && !busy)
            expected_pages.push_back(serve_request(req_func, req_free_section, req_free_slot));
      end
      outstanding = expected_pages.size();
   end

endmodule

// File: test/sectioned_page_free_list_top_tb.sv
// ----------------------------------------------------------------------------
// Sectioned page free list testbench
// Drives allocate and free requests with random sender gaps, changes the
// section count between phases while idle, fills and drains one list to its
// limit, and reports the verdict from the checker's failure and outstanding counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sectioned_page_free_list_top_tb;
   import spfl_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_func;
   logic [2:0]  req_free_section;
   logic [9:0]  req_free_slot;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_got_section;
   logic [9:0]  rsp_got_slot;
   logic [10:0] rsp_section_free_count;
   logic        csr_wr_en;
   logic [3:0]  csr_wr_data;

   int unsigned mismatches;
   int unsigned in_flight;
   int          idle_pct;
   logic [3:0]  sections_now;

   sectioned_page_free_list_top dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_func               (req_func),
      .req_free_section       (req_free_section),
      .req_free_slot          (req_free_slot),
      .rsp_valid              (rsp_valid),
      .rsp_status             (rsp_status),
      .rsp_got_section        (rsp_got_section),
      .rsp_got_slot           (rsp_got_slot),
      .rsp_section_free_count (rsp_section_free_count),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data)
   );

   sectioned_page_free_list_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_func               (req_func),
      .req_free_section       (req_free_section),
      .req_free_slot          (req_free_slot),
      .rsp_valid              (rsp_valid),
      .rsp_status             (rsp_status),
      .rsp_got_section        (rsp_got_section),
      .rsp_got_slot           (rsp_got_slot),
      .rsp_section_free_count (rsp_section_free_count),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .fail_count             (mismatches),
      .outstanding            (in_flight)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   task automatic issue_request(input logic func, input logic [2:0] sec,
                                input logic [9:0] slot);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      start            <= 1'b1;
      req_func         <= func;
      req_free_section <= sec;
      req_free_slot    <= slot;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_requests();
      @(negedge clock);
      start <= 1'b0;
      while (in_flight != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_sections(input logic [3:0] value);
      drain_requests();
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= value;
      sections_now  = value;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
   endtask

   task automatic random_item();
      int n;
      int pick;
      n    = (int'(sections_now) > SECTIONS) ? SECTIONS : int'(sections_now);
      pick = $urandom_range(99);
      if (pick < 45)
         issue_request(FUNC_ALLOC, 3'($urandom), 10'($urandom));
      else if (pick < 90 && n > 0)
         issue_request(FUNC_FREE, 3'($urandom_range(n - 1)), 10'($urandom));
      else
         issue_request(FUNC_FREE, 3'($urandom), 10'($urandom));
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_func         <= FUNC_ALLOC;
      req_free_section <= '0;
      req_free_slot    <= '0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      sections_now      = 4'd1;
      idle_pct          = 11;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one section in use from reset
      issue_request(FUNC_ALLOC, 3'd0, 10'd0);
      issue_request(FUNC_FREE, 3'd0, 10'd0);
      issue_request(FUNC_FREE, 3'd0, 10'd1023);
      issue_request(FUNC_FREE, 3'd1, 10'd5);
      issue_request(FUNC_FREE, 3'd7, 10'd1023);
      issue_request(FUNC_ALLOC, 3'd0, 10'd0);
      issue_request(FUNC_ALLOC, 3'd0, 10'd0);
      issue_request(FUNC_ALLOC, 3'd0, 10'd0);
      set_sections(4'd8);
      issue_request(FUNC_FREE, 3'd7, 10'd1023);
      issue_request(FUNC_FREE, 3'd3, 10'h2AA);
      issue_request(FUNC_FREE, 3'd0, 10'h155);
      issue_request(FUNC_ALLOC, 3'd0, 10'd0);
      issue_request(FUNC_ALLOC, 3'd0, 10'd0);
      issue_request(FUNC_ALLOC, 3'd0, 10'd0);
      issue_request(FUNC_ALLOC, 3'd7, 10'd1023);
      // no section in use
      set_sections(4'd0);
      issue_request(FUNC_ALLOC, 3'd0, 10'd0);
      issue_request(FUNC_FREE, 3'd0, 10'd3);
      // count above the section total
      set_sections(4'd15);
      issue_request(FUNC_FREE, 3'd7, 10'h3FF);
      issue_request(FUNC_FREE, 3'd5, 10'd9);
      // lowered count hides upper lists
      set_sections(4'd2);
      issue_request(FUNC_ALLOC, 3'd0, 10'd0);
      issue_request(FUNC_FREE, 3'd5, 10'd11);
      issue_request(FUNC_FREE, 3'd1, 10'd77);
      set_sections(4'd8);
      issue_request(FUNC_ALLOC, 3'd0, 10'd0);
      issue_request(FUNC_ALLOC, 3'd0, 10'd0);
      issue_request(FUNC_ALLOC, 3'd0, 10'd0);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 11 : (phase == 1) ? 76 : 0;
         set_sections(4'($urandom_range(1, 8)));
         repeat (20) random_item();
         set_sections(4'($urandom_range(0, 15)));
         repeat (20) random_item();
         set_sections(4'd8);
         repeat (20) random_item();
      end

      // fill section zero past full, then drain it past empty
      idle_pct = 0;
      set_sections(4'd1);
      repeat (1030) issue_request(FUNC_FREE, 3'd0, 10'($urandom));
      repeat (1030) issue_request(FUNC_ALLOC, 3'($urandom), 10'($urandom));

      drain_requests();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && in_flight == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end

endmodule

// File: files.f
hdl/spfl_pkg.sv
hdl/spfl_ram.sv
hdl/spfl_front.sv
hdl/spfl_queue.sv
hdl/spfl_back.sv
hdl/sectioned_page_free_list_top.sv
test/sectioned_page_free_list_checker.sv
test/sectioned_page_free_list_top_tb.sv
